/* hdl/bezier_curve_evaluator_macros.svh */
// Assertion macros for the Bezier curve evaluator.
`ifndef BEZIER_CURVE_EVALUATOR_MACROS_SVH
`define BEZIER_CURVE_EVALUATOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define BCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BCE_ASSERT_IMP(lbl, ante, cons, msg)
`define BCE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/bce_pkg.sv */
package bce_pkg;

  localparam int MaxOrderDef = 15;
  localparam int MaxDimDef   = 4;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam int  ApbAw     = 3;
  localparam logic REG_ORDER = 1'b0;
  localparam logic REG_DIM   = 1'b1;

  localparam logic [3:0] ORDER_RST = 4'd0;
  localparam logic [2:0] DIM_RST   = 3'd1;

  typedef struct packed {
    logic              cmd;
    logic [3:0]        point_index;
    logic [1:0]        axis;
    logic signed [31:0] coord_value;
    logic [16:0]       param_u;
  } bce_in_t;

  typedef struct packed {
    logic [1:0]         axis_index;
    logic signed [31:0] point_coord;
    logic               last;
  } bce_out_t;

  // travels with each blend through the lerp pipeline
  typedef struct packed {
    logic       lvl_end;
    logic       axis_end;
    logic       last;
    logic [1:0] axis;
  } bce_tag_t;

endpackage

/* hdl/bce_lerp.sv */
module bce_lerp
  import bce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic [16:0]        u_i,
  input  bce_tag_t           tag_i,
  output logic               out_vld_o,
  output logic signed [31:0] res_o,
  output bce_tag_t           tag_o,
  output logic               busy_o
);

  logic               s1_vld_q, s2_vld_q;
  logic signed [32:0] diff_d, diff_q;
  logic signed [31:0] a1_q, a2_q;
  logic signed [50:0] prod_full;
  logic [47:0]        prod_q;
  bce_tag_t           tag1_q, tag2_q;

  assign diff_d    = 33'(b_i) - 33'(a_i);
  assign prod_full = diff_q * $signed({1'b0, u_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_i) begin
      diff_q <= diff_d;
      a1_q   <= a_i;
      tag1_q <= tag_i;
    end
    if (s1_vld_q) begin
      prod_q <= prod_full[47:0];
      a2_q   <= a1_q;
      tag2_q <= tag1_q;
    end
  end

  // floor shift by 16, kept modulo 2^32
  assign res_o     = a2_q + $signed(prod_q[47:16]);
  assign out_vld_o = s2_vld_q;
  assign tag_o     = tag2_q;
  assign busy_o    = s1_vld_q | s2_vld_q;

endmodule

/* hdl/bezier_curve_evaluator.sv */
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+-------------------------------
// command   | start / busy                  | cmd_i (bce_in_t)
// result    | res_valid_o, one-cycle strobe | res_o (bce_out_t)
// config    | APB psel/penable/pwrite       | paddr, pwdata, prdata
//
// A write transaction leaves busy low.
// An evaluation of order N over D axes keeps busy high until its final axis result is shown:
// one read per cycle, except while stalled, feeds the single two-stage blend unit; each
// non-top level below 3 stalls at its first read until the level before it is written back.
// Reset clears control and config; control point memory is undefined until written.
// Results cannot be stalled; each axis result is shown for exactly one cycle.
`include "bezier_curve_evaluator_macros.svh"

module bezier_curve_evaluator
  import bce_pkg::*;
#(
  parameter int MAX_ORDER = MaxOrderDef,
  parameter int MAX_DIM   = MaxDimDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bce_in_t           cmd_i,
  output logic              res_valid_o,
  output bce_out_t          res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ApbAw-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NPts   = MAX_ORDER + 1;
  localparam int PW     = $clog2(NPts);
  localparam int AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DimLim = (MAX_DIM < 4) ? MAX_DIM : 4;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic signed [31:0] cp_mem [NPts][MAX_DIM];
  logic signed [31:0] wk_mem [NPts];

  logic [3:0]  curve_order_q;
  logic [2:0]  dim_count_q;
  logic        cfg_wr;

  logic [1:0]  state_q, state_d;
  logic [PW-1:0] i_q, i_d, lvl_q, lvl_d, wi_q, top_q;
  logic [1:0]  ax_q, ax_d, last_ax_q;
  logic        ord_zero_q;
  logic [16:0] u_q;

  logic [PW-1:0] ord_eff, top_d, rd_addr;
  logic [2:0]  dim_eff;
  logic        acc, acc_eval, wr_ok, iss, stall;

  logic               d_vld_q, d_isa_q, d_src_q;
  bce_tag_t           d_tag_q, iss_tag;
  logic signed [31:0] cp_rd_q, wk_rd_q, a_q, b_data;

  logic               lerp_vld, pipe_busy;
  logic signed [31:0] lerp_res;
  bce_tag_t           lerp_tag;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_ORDER: prdata = {28'd0, curve_order_q};
      REG_DIM:   prdata = {29'd0, dim_count_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_order_q <= ORDER_RST;
      dim_count_q   <= DIM_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ORDER: curve_order_q <= pwdata[3:0];
        REG_DIM:   dim_count_q   <= pwdata[2:0];
        default:   curve_order_q <= curve_order_q;
      endcase
    end
  end

  // effective order and axis count
  always_comb begin
    if (32'(curve_order_q) > MAX_ORDER) ord_eff = PW'(MAX_ORDER);
    else                                ord_eff = PW'(curve_order_q);
    top_d = (ord_eff == '0) ? PW'(1) : ord_eff;
    if (dim_count_q == 3'd0)             dim_eff = 3'd1;
    else if (32'(dim_count_q) > DimLim)  dim_eff = 3'(DimLim);
    else                                 dim_eff = dim_count_q;
  end

  assign busy     = (state_q != ST_IDLE);
  assign acc      = start & ~busy;
  assign acc_eval = acc & (cmd_i.cmd == CMD_EVAL);
  assign wr_ok    = (32'(cmd_i.point_index) <= MAX_ORDER) && (32'(cmd_i.axis) < MAX_DIM);

  // a short level must see every write of the level before it
  assign stall = (i_q == '0) && (lvl_q != top_q) && (32'(lvl_q) < 3) && (d_vld_q || pipe_busy);
  assign iss   = (state_q == ST_RUN) && !stall;
  assign rd_addr = ord_zero_q ? '0 : i_q;

  always_comb begin
    iss_tag.lvl_end  = (i_q == lvl_q);
    iss_tag.axis_end = (i_q == lvl_q) && (lvl_q == PW'(1));
    iss_tag.last     = (i_q == lvl_q) && (lvl_q == PW'(1)) && (ax_q == last_ax_q);
    iss_tag.axis     = ax_q;
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    lvl_d   = lvl_q;
    ax_d    = ax_q;
    case (state_q)
      ST_IDLE: begin
        if (acc_eval) begin
          state_d = ST_RUN;
          i_d     = '0;
          lvl_d   = top_d;
          ax_d    = 2'd0;
        end
      end
      ST_RUN: begin
        if (iss) begin
          if (i_q == lvl_q) begin
            i_d = '0;
            if (lvl_q == PW'(1)) begin
              if (ax_q == last_ax_q) begin
                state_d = ST_DRAIN;
              end else begin
                ax_d  = ax_q + 2'd1;
                lvl_d = top_q;
              end
            end else begin
              lvl_d = lvl_q - PW'(1);
            end
          end else begin
            i_d = i_q + PW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (lerp_vld && lerp_tag.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      lvl_q   <= '0;
      ax_q    <= 2'd0;
      wi_q    <= '0;
      d_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      lvl_q   <= lvl_d;
      ax_q    <= ax_d;
      d_vld_q <= iss;
      if (lerp_vld) wi_q <= lerp_tag.lvl_end ? '0 : wi_q + PW'(1);
    end
  end

  assign b_data = d_src_q ? cp_rd_q : wk_rd_q;

  always_ff @(posedge clk_i) begin
    if (acc && (cmd_i.cmd == CMD_WRITE) && wr_ok) begin
      cp_mem[PW'(cmd_i.point_index)][AW'(cmd_i.axis)] <= cmd_i.coord_value;
    end
    if (iss) begin
      cp_rd_q <= cp_mem[rd_addr][AW'(ax_q)];
      wk_rd_q <= wk_mem[rd_addr];
      d_isa_q <= (i_q == '0);
      d_src_q <= (lvl_q == top_q);
      d_tag_q <= iss_tag;
    end
    if (lerp_vld) wk_mem[wi_q] <= lerp_res;
    if (d_vld_q) a_q <= b_data;
    if (acc_eval) begin
      u_q        <= (cmd_i.param_u > ONE_Q16) ? ONE_Q16 : cmd_i.param_u;
      top_q      <= top_d;
      ord_zero_q <= (ord_eff == '0);
      last_ax_q  <= 2'(dim_eff - 3'd1);
    end
  end

  bce_lerp u_lerp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (d_vld_q & ~d_isa_q),
    .a_i       (a_q),
    .b_i       (b_data),
    .u_i       (u_q),
    .tag_i     (d_tag_q),
    .out_vld_o (lerp_vld),
    .res_o     (lerp_res),
    .tag_o     (lerp_tag),
    .busy_o    (pipe_busy)
  );

  assign res_valid_o       = lerp_vld & lerp_tag.axis_end;
  assign res_o.axis_index  = lerp_tag.axis;
  assign res_o.point_coord = lerp_res;
  assign res_o.last        = lerp_tag.last;

  `BCE_ASSERT_IMP(a_res_in_eval, res_valid_o, busy, "result strobe while idle")
  `BCE_ASSERT_IMP(a_idle_empty, state_q == ST_IDLE, !d_vld_q && !pipe_busy, "pipeline busy while idle")
  `BCE_ASSERT_IMP(a_last_drain, lerp_vld && lerp_tag.last, state_q == ST_DRAIN, "final blend before issue done")
  `BCE_ASSERT_NEXT(a_last_idle, res_valid_o && res_o.last, !busy, "busy after final result")

endmodule
